// ----- hdl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler package
// Shared constants, operation codes, micro-operation codes and the command
// and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

   // Table geometry and field widths.
   localparam int SLOTS    = 16;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int REQ_W    = 112;
   localparam int RSP_W    = 72;
   localparam logic [31:0] WINDOW_RESET = 32'd3600000;

   // Register byte addresses on the configuration port.
   localparam logic [2:0] ADDR_WINDOW = 3'd0;

   // Operation codes carried by a request.
   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_SETPER  = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;
   localparam logic [2:0] OP_EXPIRE  = 3'd5;

   // Micro-operations executed by the datapath.
   localparam logic [3:0] UOP_NONE    = 4'd0;
   localparam logic [3:0] UOP_LOAD    = 4'd1;
   localparam logic [3:0] UOP_ADD     = 4'd2;
   localparam logic [3:0] UOP_CANCEL  = 4'd3;
   localparam logic [3:0] UOP_RESTART = 4'd4;
   localparam logic [3:0] UOP_START   = 4'd5;
   localparam logic [3:0] UOP_SETPER  = 4'd6;
   localparam logic [3:0] UOP_OKAY    = 4'd7;
   localparam logic [3:0] UOP_INIT    = 4'd8;
   localparam logic [3:0] UOP_WAIT    = 4'd9;
   localparam logic [3:0] UOP_ROLL1   = 4'd10;
   localparam logic [3:0] UOP_ROLL2   = 4'd11;
   localparam logic [3:0] UOP_FINAL   = 4'd12;
   localparam logic [3:0] UOP_PICK    = 4'd13;

   // Kinds of table scan.
   localparam logic [1:0] SCAN_FIRST = 2'd0;
   localparam logic [1:0] SCAN_MINP  = 2'd1;
   localparam logic [1:0] SCAN_DUE   = 2'd2;
   localparam logic [1:0] SCAN_MIND  = 2'd3;

   typedef struct packed {
      logic [3:0]       uop;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             scan;
      logic [1:0]       scan_mode;
      logic             emit;
   } tts_cmd_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [IDX_W-1:0] slot;
      logic             present_s;
      logic             unchanged;
      logic             any_present;
      logic [IDX_W-1:0] best_idx;
      logic             remain_zero;
      logic             out_free;
   } tts_sts_type;

endpackage

// ----- hdl/tts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler controller
// Sequences each request through reads, table scans, updates and result
// transactions by issuing micro-operations to the datapath.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  tts_sts_type sts,
   output tts_cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_START  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_DRAIN  = 4'd5;
   localparam logic [3:0] S_POST   = 4'd6;
   localparam logic [3:0] S_SEL    = 4'd7;
   localparam logic [3:0] S_PICKRD = 4'd8;
   localparam logic [3:0] S_PICK   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;
   localparam logic [3:0] S_ROLL   = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       mode_ff, mode_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.uop  = UOP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            case (sts.op)
               OP_ADD: begin
                  cmd.uop  = UOP_ADD;
                  mode_in  = SCAN_FIRST;
                  state_in = S_SCAN;
               end
               OP_CANCEL: cmd.uop = UOP_CANCEL;
               OP_REFRESH: begin
                  if (sts.present_s) begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = sts.slot;
                     state_in    = S_EXEC;
                  end
               end
               OP_SETPER: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = sts.slot;
                  state_in    = S_EXEC;
               end
               OP_QUERY: begin
                  cmd.uop  = UOP_INIT;
                  mode_in  = SCAN_MINP;
                  state_in = S_SCAN;
               end
               OP_EXPIRE: begin
                  if (sts.any_present) begin
                     cmd.uop  = UOP_ROLL1;
                     state_in = S_ROLL;
                  end else begin
                     cmd.uop = UOP_OKAY;
                  end
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_EXEC: begin
            // Slot contents are available from the read issued in decode.
            mode_in = SCAN_FIRST;
            if (sts.op == OP_REFRESH) begin
               cmd.uop  = UOP_RESTART;
               state_in = S_SCAN;
            end else if (sts.unchanged) begin
               cmd.uop  = UOP_OKAY;
               state_in = S_EMIT;
            end else if (sts.present_s) begin
               cmd.uop  = UOP_START;
               state_in = S_START;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_START: begin
            cmd.uop  = UOP_SETPER;
            state_in = S_SCAN;
         end
         S_ROLL: begin
            cmd.uop  = UOP_ROLL2;
            mode_in  = SCAN_DUE;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = cnt_ff;
            cmd.scan      = 1'b1;
            cmd.scan_mode = mode_ff;
            if (cnt_ff == IDX_W'(SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            cmd.scan_mode = mode_ff;
            case (mode_ff)
               SCAN_FIRST: state_in = S_EMIT;
               SCAN_MIND:  state_in = S_PICKRD;
               default:    state_in = S_POST;
            endcase
         end
         S_POST: begin
            if (sts.op == OP_QUERY) begin
               cmd.uop  = UOP_WAIT;
               state_in = S_EMIT;
            end else begin
               cmd.uop  = UOP_FINAL;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (sts.remain_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.uop  = UOP_INIT;
               mode_in  = SCAN_MIND;
               state_in = S_SCAN;
            end
         end
         S_PICKRD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = sts.best_idx;
            state_in    = S_PICK;
         end
         S_PICK: begin
            cmd.uop  = UOP_PICK;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.op == OP_EXPIRE && !sts.remain_zero) begin
                  state_in = S_SEL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= SCAN_FIRST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

// ----- hdl/tts_datapath.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler datapath
// Holds the slot table, the request registers, the scan comparators and the
// result register, and executes the controller's micro-operations.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  tts_cmd_type      cmd,
   output tts_sts_type      sts,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [31:0]      window,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   // Slot table memories.
   logic [63:0] dl_mem [SLOTS];
   logic [31:0] pd_mem [SLOTS];

   logic [2:0]       op_ff, op_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [31:0]      per_ff, per_in;
   logic             rec_ff, rec_in;
   logic             fnow_ff, fnow_in;
   logic [63:0]      now_ff, now_in;
   logic [SLOTS-1:0] present_ff, present_in;
   logic [SLOTS-1:0] rep_ff, rep_in;
   logic [SLOTS-1:0] due_ff, due_in;
   logic [63:0]      rd_dl_ff;
   logic [31:0]      rd_pd_ff;
   logic             sc_v_ff;
   logic [IDX_W-1:0] sc_i_ff;
   logic [1:0]       sc_mode_ff;
   logic [63:0]      new_dl_ff, new_dl_in;
   logic             status_ff, status_in;
   logic             earliest_ff, earliest_in;
   logic [63:0]      wait_ff, wait_in;
   logic             ev_ff, ev_in;
   logic [3:0]       es_ff, es_in;
   logic             has_final_ff, has_final_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [63:0]      best_dl_ff, best_dl_in;
   logic [63:0]      prev_ff, prev_in;
   logic [64:0]      pw_ff, pw_in;
   logic             roll_ff, roll_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             dl_we, pd_we;
   logic [IDX_W-1:0] dl_wa;
   logic [63:0]      dl_wd;

   logic [63:0]      sum_now_per, sum_now_rpd, start_dif, set_sum;
   logic [64:0]      wait_dif;
   logic             cand_in_mask, cand_before;
   logic             out_free, has_now;

   assign sum_now_per = now_ff + {32'b0, per_ff};
   assign sum_now_rpd = now_ff + {32'b0, rd_pd_ff};
   assign start_dif   = rd_dl_ff - {32'b0, rd_pd_ff};
   assign set_sum     = new_dl_ff + {32'b0, per_ff};
   assign wait_dif    = {1'b0, best_dl_ff} - {1'b0, now_ff};
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign has_now     = (op_ff == OP_EXPIRE) ? has_final_ff : |present_ff;

   // Status to the controller.
   always_comb begin
      sts.op          = op_ff;
      sts.slot        = slot_ff;
      sts.present_s   = present_ff[slot_ff];
      sts.unchanged   = (per_ff == rd_pd_ff) && !fnow_ff;
      sts.any_present = |present_ff;
      sts.best_idx    = best_idx_ff;
      sts.remain_zero = (remain_ff == '0);
      sts.out_free    = out_free;
   end

   // Scan candidate qualification for the minimum searches.
   assign cand_in_mask = (sc_mode_ff == SCAN_MIND) ? due_ff[sc_i_ff] : present_ff[sc_i_ff];
   assign cand_before  = !best_valid_ff || (rd_dl_ff < best_dl_ff);

   // Micro-operation execution and scan compares.
   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      per_in       = per_ff;
      rec_in       = rec_ff;
      fnow_in      = fnow_ff;
      now_in       = now_ff;
      present_in   = present_ff;
      rep_in       = rep_ff;
      due_in       = due_ff;
      new_dl_in    = new_dl_ff;
      status_in    = status_ff;
      earliest_in  = earliest_ff;
      wait_in      = wait_ff;
      ev_in        = ev_ff;
      es_in        = es_ff;
      has_final_in = has_final_ff;
      remain_in    = remain_ff;
      best_valid_in = best_valid_ff;
      best_idx_in  = best_idx_ff;
      best_dl_in   = best_dl_ff;
      prev_in      = prev_ff;
      pw_in        = pw_ff;
      roll_in      = roll_ff;
      dl_we        = 1'b0;
      dl_wa        = slot_ff;
      dl_wd        = sum_now_per;
      pd_we        = 1'b0;

      case (cmd.uop)
         UOP_LOAD: begin
            op_in        = req_tdata[2:0];
            slot_in      = req_tdata[6:3];
            per_in       = req_tdata[38:7];
            rec_in       = req_tdata[39];
            fnow_in      = req_tdata[40];
            now_in       = req_tdata[104:41];
            status_in    = 1'b1;
            earliest_in  = 1'b0;
            wait_in      = '0;
            ev_in        = 1'b0;
            es_in        = '0;
            has_final_in = 1'b0;
            remain_in    = '0;
         end
         UOP_ADD: begin
            dl_we               = 1'b1;
            pd_we               = 1'b1;
            rep_in[slot_ff]     = rec_ff;
            present_in[slot_ff] = 1'b1;
            new_dl_in           = sum_now_per;
            status_in           = 1'b0;
            earliest_in         = 1'b1;
         end
         UOP_CANCEL: begin
            if (present_ff[slot_ff]) begin
               present_in[slot_ff] = 1'b0;
               status_in           = 1'b0;
            end
         end
         UOP_RESTART: begin
            dl_we       = 1'b1;
            dl_wd       = sum_now_rpd;
            new_dl_in   = sum_now_rpd;
            status_in   = 1'b0;
            earliest_in = 1'b1;
         end
         UOP_START: new_dl_in = fnow_ff ? now_ff : start_dif;
         UOP_SETPER: begin
            dl_we       = 1'b1;
            dl_wd       = set_sum;
            pd_we       = 1'b1;
            new_dl_in   = set_sum;
            status_in   = 1'b0;
            earliest_in = 1'b1;
         end
         UOP_OKAY: status_in = 1'b0;
         UOP_INIT: best_valid_in = 1'b0;
         UOP_WAIT: begin
            status_in = 1'b0;
            if (!best_valid_ff) begin
               wait_in = '1;
            end else if (wait_dif[64]) begin
               wait_in = '0;
            end else begin
               wait_in = wait_dif[63:0];
            end
         end
         UOP_ROLL1: begin
            // Window subtraction first; the borrow marks a window above the old time.
            pw_in     = {1'b0, prev_ff} - {33'b0, window};
            prev_in   = now_ff;
            status_in = 1'b0;
         end
         UOP_ROLL2: begin
            roll_in = !pw_ff[64] && (now_ff < pw_ff[63:0]);
            due_in  = '0;
         end
         UOP_FINAL: begin
            has_final_in = |(present_ff & ~(due_ff & ~rep_ff));
            remain_in    = CNT_W'($countones(due_ff));
         end
         UOP_PICK: begin
            due_in[best_idx_ff] = 1'b0;
            if (rep_ff[best_idx_ff]) begin
               dl_we = 1'b1;
               dl_wa = best_idx_ff;
               dl_wd = sum_now_rpd;
            end else begin
               present_in[best_idx_ff] = 1'b0;
            end
            ev_in     = 1'b1;
            es_in     = 4'(best_idx_ff);
            remain_in = remain_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase

      // One table entry is compared per cycle while a scan runs.
      if (sc_v_ff) begin
         case (sc_mode_ff)
            SCAN_FIRST: begin
               if (sc_i_ff != slot_ff && present_ff[sc_i_ff] &&
                   ((rd_dl_ff < new_dl_ff) ||
                    (rd_dl_ff == new_dl_ff && sc_i_ff < slot_ff))) begin
                  earliest_in = 1'b0;
               end
            end
            SCAN_DUE: begin
               due_in[sc_i_ff] = present_ff[sc_i_ff] && (roll_ff || rd_dl_ff <= now_ff);
            end
            default: begin
               if (cand_in_mask && cand_before) begin
                  best_valid_in = 1'b1;
                  best_idx_in   = sc_i_ff;
                  best_dl_in    = rd_dl_ff;
               end
            end
         endcase
      end
   end

   // Result register.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {has_now, wait_ff, es_ff, ev_ff, earliest_ff, status_ff};
         rsp_last_in  = (op_ff != OP_EXPIRE) || (remain_ff == '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Table memories: one write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_wa] <= dl_wd;
      end
      if (pd_we) begin
         pd_mem[slot_ff] <= per_ff;
      end
      if (cmd.rd_en) begin
         rd_dl_ff <= dl_mem[cmd.rd_addr];
         rd_pd_ff <= pd_mem[cmd.rd_addr];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         due_ff        <= '0;
         prev_ff       <= '0;
         sc_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         remain_ff     <= '0;
      end else begin
         present_ff    <= present_in;
         due_ff        <= due_in;
         prev_ff       <= prev_in;
         sc_v_ff       <= cmd.scan;
         rsp_valid_ff  <= rsp_valid_in;
         best_valid_ff <= best_valid_in;
         remain_ff     <= remain_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      per_ff       <= per_in;
      rec_ff       <= rec_in;
      fnow_ff      <= fnow_in;
      now_ff       <= now_in;
      rep_ff       <= rep_in;
      sc_i_ff      <= cmd.rd_addr;
      sc_mode_ff   <= cmd.scan_mode;
      new_dl_ff    <= new_dl_in;
      status_ff    <= status_in;
      earliest_ff  <= earliest_in;
      wait_ff      <= wait_in;
      ev_ff        <= ev_in;
      es_ff        <= es_in;
      has_final_ff <= has_final_in;
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      pw_ff        <= pw_in;
      roll_ff      <= roll_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ----- hdl/timer_table_scheduler.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler
// Ordered table of one-shot and recurring timer slots with add, cancel,
// refresh, set period, query and expire requests.
//
//   channel | direction | transaction
//   req     | in        | one request: op, slot, period, flags, current time
//   rsp     | out       | one result, or one per expired slot (tlast on final)
//   csr     | in/out    | rollover window register at byte address 0
//
// Each request passes accept, decode, slot update and result steps; add, query
// and any refresh or set period that updates a slot also run one scan of the
// table through the deadline memory read port. Expire runs a due scan, then a
// minimum scan and pick for each expired slot; on an empty table it runs no scan.
// One request is in work at a time. A stalled result holds the block in its
// result step. Reset clears the slot table's present flags and the last expire
// time.
// ----------------------------------------------------------------------------
module timer_table_scheduler import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op[2:0], slot[6:3], period_ms[38:7], recurring[39], restart_now[40],
   // now_ms[104:41], zero fill above
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[0], earliest[1], expired_valid[2], expired_slot[6:3],
   // wait_ms[70:7], has_timers[71]
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   tts_cmd_type cmd;
   tts_sts_type sts;
   logic [31:0] window_ff, window_in;

   // Configuration register access.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_WINDOW) ? window_ff : 32'b0;

   always_comb begin
      window_in = window_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_WINDOW) begin
         window_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .window     (window_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hdl/tts_checker.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler checker
// Port-level assertions on request, result and reset behavior, bound to the
// top level.
// ----------------------------------------------------------------------------
module tts_checker import tts_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only one request is in work: an accepted request closes the input.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result or busy state survived reset");

   // A failed request gives exactly one result and names no expired slot.
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tlast && !rsp_tdata[2])
      else $error("failure result is not a single plain result");

endmodule

bind timer_table_scheduler tts_checker u_tts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Timer table scheduler testbench
// Drives add, cancel, refresh, set period, query and expire requests with a
// running millisecond clock that sometimes jumps back or to random values.
// A predictor keeps its own copy of the slot table and checks every result
// transaction field by field. The rollover window is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import tts_pkg::*; ();

   // Operation codes that the block must reject.
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;
   localparam int MAX_HITS = 16;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic        recurring;
      logic        restart_now;
      logic [63:0] now_ms;
   } request_type;

   typedef struct {
      logic        status;
      logic        earliest;
      logic        expired_valid;
      logic [3:0]  expired_slot;
      logic [63:0] wait_ms;
      logic        has_timers;
      logic        last;
   } result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // op[2:0], slot[6:3], period_ms[38:7], recurring[39], restart_now[40],
   // now_ms[104:41], zero fill above
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // status[0], earliest[1], expired_valid[2], expired_slot[6:3],
   // wait_ms[70:7], has_timers[71]
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [2:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   timer_table_scheduler i_dut (.*);

   // Predicted slot table.
   logic [63:0] slot_deadline [SLOTS];
   logic [31:0] slot_period [SLOTS];
   logic        slot_repeat [SLOTS];
   logic        slot_present [SLOTS];
   logic [63:0] last_expire_ms;
   logic [31:0] window_ms;

   request_type pending_requests [$];
   result_type  expected_results [$];
   request_type cur_request;

   // Stimulus bookkeeping.
   logic        period_written [SLOTS];
   logic [63:0] clock_ms;
   bit          idle_on;
   bit          long_hold_req;
   bit          long_hold_done;
   int          send_gap;
   int          recv_hold;
   int          errors = 0;
   int          csr_errors = 0;
   int          n_requests = 0;
   int          n_results = 0;
   int          n_expired = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Ordering of two slots: earlier deadline first, lower slot on a tie.
   function automatic bit goes_first(int a, int b);
      if (slot_deadline[a] != slot_deadline[b]) return slot_deadline[a] < slot_deadline[b];
      return a < b;
   endfunction

   function automatic bit leads_table(int s);
      for (int t = 0; t < SLOTS; t++)
         if (t != s && slot_present[t] && goes_first(t, s)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit table_busy();
      for (int t = 0; t < SLOTS; t++)
         if (slot_present[t]) return 1'b1;
      return 1'b0;
   endfunction

   // Apply one request to the predicted table and queue its results.
   task automatic predict_request(request_type r);
      result_type  outs [$];
      result_type  x;
      logic [63:0] start_ms;
      bit          due [SLOTS];
      bit          roll;
      int          s;
      int          best;
      s = r.slot;
      x = '{status: 1'b1, earliest: 1'b0, expired_valid: 1'b0, expired_slot: 4'd0,
            wait_ms: 64'd0, has_timers: 1'b0, last: 1'b0};
      case (r.op)
         OP_ADD: begin
            slot_deadline[s] = r.now_ms + {32'd0, r.period_ms};
            slot_period[s] = r.period_ms;
            slot_repeat[s] = r.recurring;
            slot_present[s] = 1'b1;
            x.status = 1'b0;
            x.earliest = leads_table(s);
         end
         OP_CANCEL: begin
            if (slot_present[s]) begin
               slot_present[s] = 1'b0;
               x.status = 1'b0;
            end
         end
         OP_REFRESH: begin
            if (slot_present[s]) begin
               slot_deadline[s] = r.now_ms + {32'd0, slot_period[s]};
               x.status = 1'b0;
               x.earliest = leads_table(s);
            end
         end
         OP_SETPER: begin
            if (r.period_ms == slot_period[s] && !r.restart_now) begin
               x.status = 1'b0;
            end else if (slot_present[s]) begin
               start_ms = r.restart_now ? r.now_ms
                                        : slot_deadline[s] - {32'd0, slot_period[s]};
               slot_period[s] = r.period_ms;
               slot_deadline[s] = start_ms + {32'd0, r.period_ms};
               x.status = 1'b0;
               x.earliest = leads_table(s);
            end
         end
         OP_QUERY: begin
            x.status = 1'b0;
            x.wait_ms = '1;
            best = -1;
            for (int t = 0; t < SLOTS; t++)
               if (slot_present[t] && (best < 0 || goes_first(t, best))) best = t;
            if (best >= 0)
               x.wait_ms = (r.now_ms >= slot_deadline[best]) ? 64'd0
                                                             : slot_deadline[best] - r.now_ms;
         end
         OP_EXPIRE: begin
            x.status = 1'b0;
            if (table_busy()) begin
               roll = last_expire_ms >= {32'd0, window_ms} &&
                      r.now_ms < last_expire_ms - {32'd0, window_ms};
               last_expire_ms = r.now_ms;
               for (int t = 0; t < SLOTS; t++)
                  due[t] = slot_present[t] && (roll || slot_deadline[t] <= r.now_ms);
               while (outs.size() < MAX_HITS) begin
                  best = -1;
                  for (int t = 0; t < SLOTS; t++)
                     if (due[t] && (best < 0 || goes_first(t, best))) best = t;
                  if (best < 0) break;
                  due[best] = 1'b0;
                  if (slot_repeat[best])
                     slot_deadline[best] = r.now_ms + {32'd0, slot_period[best]};
                  else
                     slot_present[best] = 1'b0;
                  x.expired_valid = 1'b1;
                  x.expired_slot = best[3:0];
                  outs = {outs, x};
               end
               x.expired_valid = 1'b0;
               x.expired_slot = 4'd0;
            end
         end
         default: ;
      endcase
      if (outs.size() == 0) outs = {outs, x};
      foreach (outs[k]) begin
         outs[k].has_timers = table_busy();
         outs[k].last = (k == outs.size() - 1);
         expected_results = {expected_results, outs[k]};
      end
   endtask

   // Request driver: holds an offered transaction until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
         last_expire_ms = '0;
         for (int t = 0; t < SLOTS; t++) begin
            slot_present[t] = 1'b0;
            slot_period[t] = '0;
            slot_deadline[t] = '0;
            slot_repeat[t] = 1'b0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            predict_request(cur_request);
            n_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               cur_request = pending_requests.pop_front();
               req_tdata <= {7'd0, cur_request.now_ms, cur_request.restart_now,
                             cur_request.recurring, cur_request.period_ms,
                             cur_request.slot, cur_request.op};
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stalls.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (rsp_tdata[2]) n_expired++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transaction, actual %h last %b",
                        $realtime, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.status || rsp_tdata[1] !== want.earliest ||
                   rsp_tdata[2] !== want.expired_valid ||
                   rsp_tdata[6:3] !== want.expired_slot ||
                   rsp_tdata[70:7] !== want.wait_ms || rsp_tdata[71] !== want.has_timers ||
                   rsp_tlast !== want.last) begin
                  $display({"%0t: result mismatch, expected st %b ear %b ev %b es %0d",
                            " wait %h has %b last %b"},
                           $realtime, want.status, want.earliest, want.expired_valid,
                           want.expired_slot, want.wait_ms, want.has_timers, want.last);
                  $display({"%0t:                   actual st %b ear %b ev %b es %0d",
                            " wait %h has %b last %b"},
                           $realtime, rsp_tdata[0], rsp_tdata[1], rsp_tdata[2],
                           rsp_tdata[6:3], rsp_tdata[70:7], rsp_tdata[71], rsp_tlast);
                  errors++;
               end
            end
         end
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            recv_hold = 400;
         end else if (recv_hold == 0 && idle_on && $urandom_range(0, 4) == 0) begin
            recv_hold = $urandom_range(1, 9);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_request(logic [2:0] op, int slot, logic [31:0] per, bit rec, bit fnow,
                                logic [63:0] now);
      request_type r;
      r = '{op: op, slot: slot[3:0], period_ms: per, recurring: rec, restart_now: fnow,
            now_ms: now};
      if (op == OP_ADD) period_written[slot] = 1'b1;
      pending_requests = {pending_requests, r};
   endtask

   // One random request; mostly a steady clock with small periods so timers fire.
   task automatic queue_random();
      logic [2:0]  op;
      logic [31:0] per;
      int          pick;
      int          s;
      bit          fnow;
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, SLOTS - 1);
      per = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500);
      fnow = $urandom_range(0, 1);
      if (pick < 25) op = OP_ADD;
      else if (pick < 35) op = OP_CANCEL;
      else if (pick < 45) op = OP_REFRESH;
      else if (pick < 60) op = OP_SETPER;
      else if (pick < 73) op = OP_QUERY;
      else if (pick < 96) op = OP_EXPIRE;
      else op = pick[0] ? OP_BAD7 : OP_BAD6;
      // The unchanged set period check needs a stored period.
      if (op == OP_SETPER && !period_written[s]) fnow = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ms = {$urandom(), $urandom()};
      else if (pick < 7) clock_ms = clock_ms - $urandom_range(0, 5000000);
      else clock_ms = clock_ms + $urandom_range(0, 400);
      queue_request(op, s, per, $urandom_range(0, 1), fnow, clock_ms);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_requests.size() > 0 || req_tvalid || expected_results.size() > 0);
      repeat (40) @(negedge clock);
   endtask

   // Register write followed by a read back.
   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      window_ms = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t: window read back, expected %h actual %h", $realtime, value, csr_prdata);
         csr_errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      idle_on = 1'b1;
      long_hold_req = 1'b0;
      window_ms = WINDOW_RESET;
      clock_ms = 64'd10000000;
      for (int t = 0; t < SLOTS; t++) begin
         period_written[t] = 1'b0;
      end
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = ADDR_WINDOW;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, failures, every operation, extremes.
      queue_request(OP_EXPIRE, 0, 0, 0, 0, 64'd5);
      queue_request(OP_QUERY, 0, 0, 0, 0, 64'd5);
      queue_request(OP_CANCEL, 3, 0, 0, 0, 64'd5);
      queue_request(OP_REFRESH, 3, 0, 0, 0, 64'd5);
      queue_request(OP_SETPER, 3, 32'd7, 0, 1, 64'd5);
      queue_request(OP_BAD6, 1, 32'hFFFFFFFF, 1, 1, '1);
      queue_request(OP_BAD7, 2, 0, 0, 0, 64'd5);
      queue_request(OP_ADD, 0, 0, 0, 0, 64'd0);
      queue_request(OP_ADD, 15, 32'hFFFFFFFF, 1, 0, '1);
      queue_request(OP_ADD, 5, 32'd100, 1, 0, 64'd1000);
      queue_request(OP_ADD, 5, 32'd50, 0, 0, 64'd1000);
      queue_request(OP_SETPER, 0, 32'd0, 0, 0, 64'd2000);
      queue_request(OP_SETPER, 5, 32'd80, 0, 0, 64'd2000);
      queue_request(OP_SETPER, 5, 32'd90, 0, 1, 64'd1000);
      queue_request(OP_REFRESH, 15, 0, 0, 0, 64'd0);
      queue_request(OP_QUERY, 0, 0, 0, 0, 64'd1010);
      queue_request(OP_CANCEL, 0, 0, 0, 0, 64'd1010);
      for (int t = 0; t < SLOTS; t++) queue_request(OP_ADD, t, 32'd10, t[0], 0, 64'd4000000);
      queue_request(OP_EXPIRE, 0, 0, 0, 0, 64'd4000010);
      queue_request(OP_EXPIRE, 0, 0, 0, 0, 64'd4000011);
      queue_request(OP_EXPIRE, 0, 0, 0, 0, 64'd100);
      queue_request(OP_QUERY, 0, 0, 0, 0, 64'd100);
      for (int k = 0; k < 90; k++) queue_random();
      wait_quiet();

      // Zero window: any backward step is a rollover. Receiver holds off long.
      csr_write(ADDR_WINDOW, 32'd0);
      for (int k = 0; k < 100; k++) queue_random();
      long_hold_req = 1'b1;
      wait_quiet();

      csr_write(ADDR_WINDOW, 32'hFFFFFFFF);
      for (int k = 0; k < 100; k++) queue_random();
      wait_quiet();

      // Small window; the second half runs without idling.
      csr_write(ADDR_WINDOW, 32'd1000);
      for (int k = 0; k < 50; k++) queue_random();
      wait_quiet();
      idle_on = 1'b0;
      for (int k = 0; k < 60; k++) queue_random();
      wait_quiet();

      $display("tb: %0d requests, %0d results, %0d expired timers, 4 window settings",
               n_requests, n_results, n_expired);
      $display("tb: %0d mismatches", errors + csr_errors);
      if (errors + csr_errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #50ms;
      $display("tb: FAIL");
      $finish;
   end

endmodule
